@@ design/spts_pkg.sv @@
package spts_pkg;

    localparam int SlotW = 40;
    localparam int NumW  = 32;
    localparam int CtW   = 8;
    localparam int RetW  = 4;

    typedef enum logic [2:0] {
        FN_REQUEST = 3'd0,
        FN_TICK    = 3'd1,
        FN_OUTCOME = 3'd2,
        FN_CANCEL  = 3'd3,
        FN_QUERY   = 3'd4
    } t_func;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOJOB  = 2'd2;

    localparam logic [1:0] CH_EVEN = 2'd0;
    localparam logic [1:0] CH_ODD  = 2'd1;

    localparam logic [0:0] REG_RETRY_LIMIT = 1'd0;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item, clear scan state
        logic scan;     // examine the entry at the scan index
        logic finish;   // apply the update and build the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_stat;

endpackage

@@ design/spts_ctrl.sv @@
module spts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  spts_pkg::t_stat i_stat,
    output spts_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/spts_dp.sv @@
module spts_dp #(
    parameter int JOB_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spts_pkg::t_cmd                i_cmd,
    output spts_pkg::t_stat               o_stat,
    input  logic [spts_pkg::RetW-1:0]     i_retry_limit,
    input  logic [2:0]                    i_func,
    input  logic [spts_pkg::SlotW-1:0]    i_slot_now,
    input  logic [spts_pkg::CtW-1:0]      i_contact_id,
    input  logic [1:0]                    i_slot_choice,
    input  logic                          i_contact_done,
    output logic [1:0]                    o_status,
    output logic                          o_transmit_now,
    output logic [spts_pkg::NumW-1:0]     o_job_number,
    output logic [spts_pkg::CtW-1:0]      o_job_contact,
    output logic [spts_pkg::SlotW-1:0]    o_job_slot,
    output logic [spts_pkg::RetW-1:0]     o_job_retries
);

    localparam int IW = (JOB_ENTRIES > 1) ? $clog2(JOB_ENTRIES) : 1;
    localparam int SW = spts_pkg::SlotW;

    // table
    logic                     r_used  [JOB_ENTRIES];
    logic                     r_canc  [JOB_ENTRIES];
    logic [spts_pkg::NumW-1:0] r_num  [JOB_ENTRIES];
    logic [spts_pkg::CtW-1:0]  r_ct   [JOB_ENTRIES];
    logic [SW-1:0]             r_slot [JOB_ENTRIES];
    logic                      r_par  [JOB_ENTRIES];
    logic [spts_pkg::RetW-1:0] r_ret  [JOB_ENTRIES];

    logic [IW-1:0]             r_pick;
    logic                      r_pick_v;
    logic [spts_pkg::NumW-1:0] r_id;

    // captured item
    logic [2:0]                r_func;
    logic [SW-1:0]             r_now;
    logic [spts_pkg::CtW-1:0]  r_cid;
    logic [1:0]                r_choice;
    logic                      r_done;

    // scan state
    logic [IW-1:0]             r_idx;
    logic                      r_hit;   // free / best / pending found
    logic [IW-1:0]             r_hidx;
    logic                      r_seen;  // query: first entry of the contact seen
    logic [spts_pkg::RetW-1:0] r_rcnt;
    logic                      r_any;   // cancel: live job cancelled

    logic [SW-1:0] w_next;
    logic          w_live, w_cmatch, w_free;
    logic [SW-1:0] w_ts;

    assign w_next   = r_now + SW'(1);
    assign w_live   = r_used[r_idx] && !r_canc[r_idx];
    assign w_cmatch = r_used[r_idx] && (r_ct[r_idx] == r_cid);
    assign w_free   = !w_live;
    assign w_ts     = r_slot[r_idx];
    assign o_stat.scan_last = (r_idx == IW'(JOB_ENTRIES - 1));

    // request target
    logic [SW-1:0] w_target;
    logic          w_tpar;
    always_comb begin
        unique case (r_choice)
            spts_pkg::CH_EVEN: begin
                w_target = r_now[0] ? r_now + SW'(1) : r_now + SW'(2);
                w_tpar   = 1'b0;
            end
            spts_pkg::CH_ODD: begin
                w_target = r_now[0] ? r_now + SW'(2) : r_now + SW'(1);
                w_tpar   = 1'b1;
            end
            default: begin
                w_target = r_now + SW'(1);
                w_tpar   = w_target[0];
            end
        endcase
    end

    logic [SW-1:0] w_rs0, w_rs;
    assign w_rs0 = r_now + SW'(3);
    assign w_rs  = (w_rs0[0] != r_par[r_pick]) ? w_rs0 + SW'(1) : w_rs0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOB_ENTRIES; k++) begin
                r_used[k] <= 1'b0;
                r_canc[k] <= 1'b0;
            end
            r_pick   <= '0;
            r_pick_v <= 1'b0;
            r_id     <= spts_pkg::NumW'(1);
            r_idx    <= '0;
            r_hit    <= 1'b0;
        end else if (i_cmd.load) begin
            r_func   <= i_func;
            r_now    <= i_slot_now;
            r_cid    <= i_contact_id;
            r_choice <= i_slot_choice;
            r_done   <= i_contact_done;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_hidx   <= '0;
            r_seen   <= 1'b0;
            r_rcnt   <= '0;
            r_any    <= 1'b0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + IW'(1);
            unique case (r_func)
                spts_pkg::FN_REQUEST: begin
                    if (!r_hit && w_free) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_idx;
                    end
                end
                spts_pkg::FN_TICK: begin
                    if (w_live && w_ts <= w_next &&
                        (!r_hit || w_ts < r_slot[r_hidx])) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_idx;
                    end
                end
                spts_pkg::FN_CANCEL: begin
                    if (w_cmatch) begin
                        if (!r_canc[r_idx]) r_any <= 1'b1;
                        r_canc[r_idx] <= 1'b1;
                    end
                end
                spts_pkg::FN_QUERY: begin
                    if (w_cmatch) begin
                        if (!r_seen) begin
                            r_seen <= 1'b1;
                            r_rcnt <= r_ret[r_idx];
                        end
                        if (!r_hit && !r_canc[r_idx]) begin
                            r_hit  <= 1'b1;
                            r_hidx <= r_idx;
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.finish) begin
            o_status       <= spts_pkg::ST_NOJOB;
            o_transmit_now <= 1'b0;
            o_job_number   <= '0;
            o_job_contact  <= '0;
            o_job_slot     <= '0;
            o_job_retries  <= '0;
            unique case (r_func)
                spts_pkg::FN_REQUEST: begin
                    if (!r_hit) begin
                        o_status <= spts_pkg::ST_FULL;
                    end else begin
                        if (r_pick_v && r_pick == r_hidx) r_pick_v <= 1'b0;
                        r_used[r_hidx] <= 1'b1;
                        r_canc[r_hidx] <= 1'b0;
                        r_num[r_hidx]  <= r_id;
                        r_ct[r_hidx]   <= r_cid;
                        r_slot[r_hidx] <= w_target;
                        r_par[r_hidx]  <= w_tpar;
                        r_ret[r_hidx]  <= '0;
                        r_id           <= r_id + spts_pkg::NumW'(1);
                        o_status       <= spts_pkg::ST_OK;
                        o_job_number   <= r_id;
                        o_job_contact  <= r_cid;
                        o_job_slot     <= w_target;
                    end
                end
                spts_pkg::FN_TICK: begin
                    o_status <= spts_pkg::ST_OK;
                    if (r_hit && r_par[r_hidx] == w_next[0]) begin
                        r_pick_v       <= 1'b1;
                        r_pick         <= r_hidx;
                        o_transmit_now <= 1'b1;
                        o_job_number   <= r_num[r_hidx];
                        o_job_contact  <= r_ct[r_hidx];
                        o_job_slot     <= r_slot[r_hidx];
                        o_job_retries  <= r_ret[r_hidx];
                    end else begin
                        r_pick_v <= 1'b0;
                    end
                end
                spts_pkg::FN_OUTCOME: begin
                    r_pick_v <= 1'b0;
                    if (r_pick_v && r_used[r_pick] && !r_canc[r_pick]) begin
                        o_status      <= spts_pkg::ST_OK;
                        o_job_number  <= r_num[r_pick];
                        o_job_contact <= r_ct[r_pick];
                        if (r_done || r_ret[r_pick] >= i_retry_limit) begin
                            r_canc[r_pick] <= 1'b1;
                            o_job_slot     <= r_slot[r_pick];
                            o_job_retries  <= r_ret[r_pick];
                        end else begin
                            r_ret[r_pick]  <= r_ret[r_pick] + spts_pkg::RetW'(1);
                            r_slot[r_pick] <= w_rs;
                            o_job_slot     <= w_rs;
                            o_job_retries  <= r_ret[r_pick] + spts_pkg::RetW'(1);
                        end
                    end
                end
                spts_pkg::FN_CANCEL: begin
                    o_status <= r_any ? spts_pkg::ST_OK : spts_pkg::ST_NOJOB;
                end
                spts_pkg::FN_QUERY: begin
                    o_job_retries <= r_rcnt;
                    if (r_hit) begin
                        o_status      <= spts_pkg::ST_OK;
                        o_job_number  <= r_num[r_hidx];
                        o_job_contact <= r_ct[r_hidx];
                        o_job_slot    <= r_slot[r_hidx];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ design/slot_parity_tx_job_scheduler_core.sv @@
// Transmit job table with JOB_ENTRIES entries. The result of an accepted item is valid
// after a sequential scan over every table entry and then an update step. The next item
// is taken the cycle after the result has been transferred, so items are handled one at
// a time, and an output that waits for ready holds off the next item.
// retry_limit sits at byte address 0 of the register port and resets to 3.
module slot_parity_tx_job_scheduler_core #(
    parameter int JOB_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [39:0] i_slot_now,
    input  logic [7:0]  i_contact_id,
    input  logic [1:0]  i_slot_choice,
    input  logic        i_contact_done,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_transmit_now,
    output logic [31:0] o_job_number,
    output logic [7:0]  o_job_contact,
    output logic [39:0] o_job_slot,
    output logic [3:0]  o_job_retries
);

    logic [3:0]      r_retry_limit;
    spts_pkg::t_cmd  w_cmd;
    spts_pkg::t_stat w_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == spts_pkg::REG_RETRY_LIMIT) ? {28'd0, r_retry_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= 4'd3;
        end else if (psel && penable && pwrite && paddr == spts_pkg::REG_RETRY_LIMIT) begin
            r_retry_limit <= pwdata[3:0];
        end
    end

    spts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    spts_dp #(.JOB_ENTRIES(JOB_ENTRIES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_retry_limit  (r_retry_limit),
        .i_func         (i_func),
        .i_slot_now     (i_slot_now),
        .i_contact_id   (i_contact_id),
        .i_slot_choice  (i_slot_choice),
        .i_contact_done (i_contact_done),
        .o_status       (o_status),
        .o_transmit_now (o_transmit_now),
        .o_job_number   (o_job_number),
        .o_job_contact  (o_job_contact),
        .o_job_slot     (o_job_slot),
        .o_job_retries  (o_job_retries)
    );

endmodule

@@ design/spts_checker.sv @@
module spts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic       o_transmit_now
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready while result pending");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= spts_pkg::ST_NOJOB))
        else $error("bad status code");

    a_tx_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transmit_now) |-> (o_status == spts_pkg::ST_OK))
        else $error("transmit with error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("result dropped");

endmodule

bind slot_parity_tx_job_scheduler_core spts_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_transmit_now (o_transmit_now)
);

@@ dv/slot_parity_tx_job_scheduler_core_tb.sv @@
module slot_parity_tx_job_scheduler_core_tb;

    localparam int Entries = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_in_valid, o_in_ready;
    logic [2:0]  i_func;
    logic [39:0] i_slot_now;
    logic [7:0]  i_contact_id;
    logic [1:0]  i_slot_choice;
    logic        i_contact_done;
    logic        o_out_valid, i_out_ready;
    logic [1:0]  o_status;
    logic        o_transmit_now;
    logic [31:0] o_job_number;
    logic [7:0]  o_job_contact;
    logic [39:0] o_job_slot;
    logic [3:0]  o_job_retries;

    slot_parity_tx_job_scheduler_core #(.JOB_ENTRIES(Entries)) uut (.*);

    typedef struct packed {
        logic [1:0]  status;
        logic        tx;
        logic [31:0] number;
        logic [7:0]  contact;
        logic [39:0] slot;
        logic [3:0]  retries;
    } t_job_result;

    // predictor copy of the job table
    logic        tbl_used [Entries];
    logic        tbl_cancel [Entries];
    logic [31:0] tbl_number [Entries];
    logic [7:0]  tbl_contact [Entries];
    logic [39:0] tbl_slot [Entries];
    logic        tbl_parity [Entries];
    logic [3:0]  tbl_retries [Entries];
    int          pick_idx;
    logic        pick_ok;
    logic [31:0] next_id;
    logic [3:0]  retry_limit;

    t_job_result pending_results[$];
    int  errors = 0;
    int  idle_mode = 0; // 0 bursty, 1 never idle
    logic [39:0] base_slot;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic t_job_result entry_result(logic [1:0] st, logic tx, int e);
        t_job_result r;
        r = '0;
        r.status = st;
        r.tx = tx;
        if (e >= 0) begin
            r.number = tbl_number[e];
            r.contact = tbl_contact[e];
            r.slot = tbl_slot[e];
            r.retries = tbl_retries[e];
        end
        return r;
    endfunction

    function automatic t_job_result schedule_job(logic [2:0] fn, logic [39:0] now,
                                                 logic [7:0] ct, logic [1:0] ch,
                                                 logic done);
        int          e, best, pend;
        logic [39:0] target, nxt, rs;
        logic        par, any, seen;
        logic [3:0]  rc;
        t_job_result r;
        e = -1; best = -1; pend = -1; any = 0; seen = 0; rc = '0;
        case (fn)
            spts_pkg::FN_REQUEST: begin
                for (int i = Entries - 1; i >= 0; i--)
                    if (!tbl_used[i] || tbl_cancel[i]) e = i;
                if (e < 0) return entry_result(spts_pkg::ST_FULL, 1'b0, -1);
                if (ch == spts_pkg::CH_EVEN) begin
                    target = now[0] ? now + 40'd1 : now + 40'd2;
                    par = 1'b0;
                end else if (ch == spts_pkg::CH_ODD) begin
                    target = now[0] ? now + 40'd2 : now + 40'd1;
                    par = 1'b1;
                end else begin
                    target = now + 40'd1;
                    par = target[0];
                end
                if (pick_ok && pick_idx == e) pick_ok = 1'b0;
                tbl_used[e] = 1'b1;
                tbl_cancel[e] = 1'b0;
                tbl_number[e] = next_id;
                tbl_contact[e] = ct;
                tbl_slot[e] = target;
                tbl_parity[e] = par;
                tbl_retries[e] = '0;
                next_id = next_id + 32'd1;
                return entry_result(spts_pkg::ST_OK, 1'b0, e);
            end
            spts_pkg::FN_TICK: begin
                nxt = now + 40'd1;
                for (int i = 0; i < Entries; i++) begin
                    if (!tbl_used[i] || tbl_cancel[i] || tbl_slot[i] > nxt) continue;
                    if (best < 0 || tbl_slot[i] < tbl_slot[best]) best = i;
                end
                if (best >= 0 && tbl_parity[best] != nxt[0]) best = -1;
                if (best < 0) begin
                    pick_ok = 1'b0;
                    return entry_result(spts_pkg::ST_OK, 1'b0, -1);
                end
                pick_ok = 1'b1;
                pick_idx = best;
                return entry_result(spts_pkg::ST_OK, 1'b1, best);
            end
            spts_pkg::FN_OUTCOME: begin
                if (!pick_ok) return entry_result(spts_pkg::ST_NOJOB, 1'b0, -1);
                pick_ok = 1'b0;
                e = pick_idx;
                if (!tbl_used[e] || tbl_cancel[e])
                    return entry_result(spts_pkg::ST_NOJOB, 1'b0, -1);
                if (done || tbl_retries[e] >= retry_limit) begin
                    tbl_cancel[e] = 1'b1;
                end else begin
                    rs = now + 40'd3;
                    tbl_retries[e] = tbl_retries[e] + 4'd1;
                    if (rs[0] != tbl_parity[e]) rs = rs + 40'd1;
                    tbl_slot[e] = rs;
                end
                return entry_result(spts_pkg::ST_OK, 1'b0, e);
            end
            spts_pkg::FN_CANCEL: begin
                for (int i = 0; i < Entries; i++)
                    if (tbl_used[i] && tbl_contact[i] == ct) begin
                        if (!tbl_cancel[i]) any = 1'b1;
                        tbl_cancel[i] = 1'b1;
                    end
                return entry_result(any ? spts_pkg::ST_OK : spts_pkg::ST_NOJOB, 1'b0, -1);
            end
            spts_pkg::FN_QUERY: begin
                for (int i = 0; i < Entries; i++) begin
                    if (!tbl_used[i] || tbl_contact[i] != ct) continue;
                    if (!seen) begin
                        rc = tbl_retries[i];
                        seen = 1'b1;
                    end
                    if (pend < 0 && !tbl_cancel[i]) pend = i;
                end
                r = entry_result(pend >= 0 ? spts_pkg::ST_OK : spts_pkg::ST_NOJOB, 1'b0, pend);
                r.retries = rc;
                return r;
            end
            default: return entry_result(spts_pkg::ST_NOJOB, 1'b0, -1);
        endcase
    endfunction

    task automatic send_job_event(logic [2:0] fn, logic [39:0] now, logic [7:0] ct,
                                  logic [1:0] ch, logic done);
        int gap;
        gap = 1;
        if (idle_mode == 0 && $urandom_range(0, 3) == 0) gap = $urandom_range(2, 7);
        repeat (gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_slot_now <= now;
        i_contact_id <= ct;
        i_slot_choice <= ch;
        i_contact_done <= done;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), schedule_job(fn, now, ct, ch, done));
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_retry_limit(logic [3:0] v);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= spts_pkg::REG_RETRY_LIMIT; pwdata <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        retry_limit = v;
    endtask

    // receiver stall pattern and result check
    int stall_ctr = 0;
    always @(posedge i_clk) begin
        t_job_result got, want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_ctr <= stall_ctr + 1;
            i_out_ready <= (stall_ctr % 64 < 20) ? 1'b1 : ((stall_ctr * 7) % 5 != 0);
            if (o_out_valid && i_out_ready) begin
                got = {o_status, o_transmit_now, o_job_number, o_job_contact,
                       o_job_slot, o_job_retries};
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        logic [39:0] top;
        top = 40'hFF_FFFF_FFFF;
        send_job_event(spts_pkg::FN_OUTCOME, 40'd5, 8'd1, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_QUERY, 40'd5, 8'd9, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_CANCEL, 40'd5, 8'd9, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_REQUEST, 40'd10, 8'd0, spts_pkg::CH_EVEN, 1'b0);
        send_job_event(spts_pkg::FN_REQUEST, 40'd11, 8'd255, spts_pkg::CH_ODD, 1'b1);
        send_job_event(spts_pkg::FN_REQUEST, top, 8'd7, 2'd2, 1'b0);
        send_job_event(spts_pkg::FN_REQUEST, top - 40'd1, 8'd8, 2'd3, 1'b0);
        send_job_event(spts_pkg::FN_TICK, 40'd11, 8'd0, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_OUTCOME, 40'd11, 8'd0, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_TICK, 40'd13, 8'd0, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_TICK, 40'd12, 8'd0, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_OUTCOME, 40'd12, 8'd0, 2'd0, 1'b1);
        send_job_event(spts_pkg::FN_QUERY, 40'd0, 8'd255, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_CANCEL, 40'd0, 8'd255, 2'd0, 1'b0);
        send_job_event(spts_pkg::FN_QUERY, 40'd0, 8'd255, 2'd0, 1'b0);
        send_job_event(3'd5, 40'd0, 8'd0, 2'd0, 1'b0);
        send_job_event(3'd7, top, 8'd255, 2'd3, 1'b1);
        for (int i = 0; i < 16; i++)
            send_job_event(spts_pkg::FN_REQUEST, 40'd20 + i, i[7:0], 2'd2, 1'b0);
    endtask

    // scheduling loops: request, tick, outcome, cancel, query and unused function codes around a moving slot
    task automatic test_random(int n);
        logic [2:0]  fn;
        logic [39:0] now;
        int          k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25) fn = spts_pkg::FN_REQUEST;
            else if (k < 55) fn = spts_pkg::FN_TICK;
            else if (k < 80) fn = spts_pkg::FN_OUTCOME;
            else if (k < 88) fn = spts_pkg::FN_CANCEL;
            else if (k < 97) fn = spts_pkg::FN_QUERY;
            else fn = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 19) == 0) now = 40'({$urandom, $urandom});
            else begin
                base_slot = base_slot + 40'($urandom_range(0, 2));
                now = base_slot;
            end
            send_job_event(fn, now, 8'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 5)),
                           2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_retry_limits();
        logic [3:0] lims [4] = '{4'd0, 4'd15, 4'd1, 4'd3};
        foreach (lims[j]) begin
            write_retry_limit(lims[j]);
            test_random(200);
        end
    endtask

    task automatic test_wrap();
        idle_mode = 1;
        base_slot = 40'hFF_FFFF_FFF0;
        test_random(130);
        idle_mode = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_func = '0; i_slot_now = '0; i_contact_id = '0;
        i_slot_choice = '0; i_contact_done = 1'b0;
        foreach (tbl_used[i]) begin
            tbl_used[i] = 1'b0; tbl_cancel[i] = 1'b0; tbl_number[i] = '0;
            tbl_contact[i] = '0; tbl_slot[i] = '0; tbl_parity[i] = 1'b0;
            tbl_retries[i] = '0;
        end
        pick_idx = 0; pick_ok = 1'b0; next_id = 32'd1; retry_limit = 4'd3;
        base_slot = 40'd100;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(20);
        test_retry_limits();
        test_wrap();
        wait_drained();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
design/spts_pkg.sv
design/spts_ctrl.sv
design/spts_dp.sv
design/slot_parity_tx_job_scheduler_core.sv
design/spts_checker.sv
dv/slot_parity_tx_job_scheduler_core_tb.sv
